FILE: hw/rtl/ifri_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ifri_pkg: shared types and constants of the image flip/rotate/invert engine
// Field widths, register indexes, mode codes and the result queue shape.
// ----------------------------------------------------------------------------
package ifri_pkg;

	localparam int PIX_W      = 8;
	localparam int DIM_W      = 9;
	localparam int TOT_W      = 2 * DIM_W;
	localparam int MODE_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int DIM_RESET      = 256;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	// transform codes; the remaining codes pass pixels through in input order
	localparam logic [MODE_W-1:0] MODE_INVERT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_VFLIP  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_HFLIP  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CW     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CCW    = 3'd4;

	// result queue: depth must be a power of two
	localparam int OFIFO_DEPTH = 8;
	localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
	} out_word_t;

	// zero acts as one, anything above the maximum saturates
	function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int maxv);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (int'(v) > maxv) begin
			r = DIM_W'(maxv);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ifri_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ifri_store: frame store
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module ifri_store #(
	parameter int DEPTH  = 65536,
	parameter int ADDR_W = 16
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic                       we,
	input  wire logic [ADDR_W-1:0]          addr,
	input  wire logic [ifri_pkg::PIX_W-1:0] wdata,
	output logic      [ifri_pkg::PIX_W-1:0] rdata
);
	import ifri_pkg::*;

	logic [PIX_W-1:0] store_mem [DEPTH];
	logic [PIX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				store_mem[addr] <= wdata;
			end else begin
				rdata_q <= store_mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: hw/rtl/ifri_ofifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ifri_ofifo: result queue
// Small register queue that decouples the store pipeline from the result side.
// ----------------------------------------------------------------------------
module ifri_ofifo (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	input  wire ifri_pkg::out_word_t              push_word,
	input  wire logic                             pop,
	output logic                                  head_valid,
	output ifri_pkg::out_word_t                   head_word,
	output logic [ifri_pkg::OFIFO_CNT_W-1:0]      count
);
	import ifri_pkg::*;

	localparam int PTR_W = (OFIFO_DEPTH > 1) ? $clog2(OFIFO_DEPTH) : 1;

	out_word_t              fifo_mem_q [OFIFO_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [OFIFO_CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + OFIFO_CNT_W'(1);
				2'b01:   count_q <= count_q - OFIFO_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head_valid = (count_q != '0);
	assign head_word  = fifo_mem_q[rd_ptr_q];
	assign count      = count_q;

endmodule
`default_nettype wire

FILE: hw/rtl/image_flip_rotate_invert.sv
`default_nettype none
// ----------------------------------------------------------------------------
// image_flip_rotate_invert: frame-buffer flip, rotate and invert engine
// Loads 8-bit grayscale pixels in raster order and plays the frame back
// inverted, flipped top-bottom or left-right, or rotated by 90 degrees.
// ----------------------------------------------------------------------------
// An item with op 0 writes pixel_in to the next raster position of the frame
// store; an item with op 1 returns one word, the next pixel of the transformed
// frame in output raster order, with frame_last set on the final pixel. Rotated
// frames come out frame_height wide and frame_width high. Items are taken at
// one per cycle while item_stall is low: the store is a single-port RAM
// doing one access per cycle, and that port sets the rate. A read item reaches
// result_valid through an address stage, a multiply-add stage, RAM read, queue.
// Up to eight read results may be in flight or queued; past that item_stall
// rises until the result side drains. item_stall is also high in the
// cycle after each configuration write, while the frame size product settles.
// Configuration writes are always taken (cfg_ready stays high) and must only
// be issued while the engine is idle. The store has no reset or clearing pass:
// reading a position never written returns whatever the RAM holds.
// ----------------------------------------------------------------------------
module image_flip_rotate_invert #(
	parameter int MAX_WIDTH  = ifri_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = ifri_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// item channel
	input  wire logic                            item_valid,
	output logic                                 item_stall,
	input  wire logic                            op,
	input  wire logic [ifri_pkg::PIX_W-1:0]      pixel_in,
	// result channel
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output logic      [ifri_pkg::PIX_W-1:0]      pixel_out,
	output logic                                 frame_last,
	// configuration channel
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ifri_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ifri_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ifri_pkg::*;

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// linear index width: wide enough for both the address and a frame offset
	localparam int LIN_W  = (ADDR_W > TOT_W) ? ADDR_W : TOT_W;
	localparam int CRED_W = OFIFO_CNT_W + 1;
	localparam logic [DIM_W-1:0] W_RST =
		DIM_W'((MAX_WIDTH < DIM_RESET) ? MAX_WIDTH : DIM_RESET);
	localparam logic [DIM_W-1:0] H_RST =
		DIM_W'((MAX_HEIGHT < DIM_RESET) ? MAX_HEIGHT : DIM_RESET);
	localparam logic [TOT_W-1:0] TOTAL_RST = TOT_W'(int'(W_RST) * int'(H_RST));

	// ------------------------------------------------------------------
	// Configuration registers. Dimensions are clamped as they are written,
	// and the pixel count of the frame follows in the next cycle.
	// ------------------------------------------------------------------
	logic              cfg_we;
	logic [MODE_W-1:0] mode_q;
	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [TOT_W-1:0]  total_q;
	logic              cfg_pend_q;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_INVERT;
			width_q    <= W_RST;
			height_q   <= H_RST;
			total_q    <= TOTAL_RST;
			cfg_pend_q <= 1'b0;
		end else begin
			cfg_pend_q <= cfg_we;
			total_q    <= TOT_W'(width_q) * TOT_W'(height_q);
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:   mode_q   <= cfg_data[MODE_W-1:0];
					REG_WIDTH:  width_q  <= clamp_dim(cfg_data, MAX_WIDTH);
					REG_HEIGHT: height_q <= clamp_dim(cfg_data, MAX_HEIGHT);
					default:    ;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Item acceptance
	// ------------------------------------------------------------------
	logic item_acc;
	logic wr_acc;
	logic rd_acc;

	assign item_acc = item_valid && !item_stall;
	assign wr_acc   = item_acc && !op;
	assign rd_acc   = item_acc && op;

	// ------------------------------------------------------------------
	// Load position: linear raster index of the next write. Restart at 0
	// if it lies beyond the frame (after a size change), wrap at frame end.
	// ------------------------------------------------------------------
	logic [TOT_W-1:0] load_q;
	logic [TOT_W-1:0] load_cur;
	logic [TOT_W-1:0] load_inc;
	logic [TOT_W-1:0] load_nxt;

	always_comb begin
		load_cur = (load_q >= total_q) ? '0 : load_q;
		load_inc = load_cur + TOT_W'(1);
		load_nxt = (load_inc >= total_q) ? '0 : load_inc;
	end

	// ------------------------------------------------------------------
	// Read position: output row (outer) and column (inner) counters,
	// mapped back to an input row and column by the mode.
	// ------------------------------------------------------------------
	logic [DIM_W-1:0] out_outer_q;
	logic [DIM_W-1:0] out_inner_q;
	logic             rotated;
	logic [DIM_W-1:0] olen;
	logic [DIM_W-1:0] ilen;
	logic [DIM_W-1:0] oo;
	logic [DIM_W-1:0] ii;
	logic [DIM_W-1:0] src_row;
	logic [DIM_W-1:0] src_col;
	logic             inner_end;
	logic             outer_end;
	logic [DIM_W-1:0] outer_nxt;
	logic [DIM_W-1:0] inner_nxt;

	always_comb begin
		rotated = (mode_q == MODE_CW) || (mode_q == MODE_CCW);
		olen    = rotated ? width_q  : height_q;
		ilen    = rotated ? height_q : width_q;
		// counters left outside the output frame by a mode or size change
		if ((out_outer_q >= olen) || (out_inner_q >= ilen)) begin
			oo = '0;
			ii = '0;
		end else begin
			oo = out_outer_q;
			ii = out_inner_q;
		end

		case (mode_q)
			MODE_VFLIP: begin
				src_row = height_q - DIM_W'(1) - oo;
				src_col = ii;
			end
			MODE_HFLIP: begin
				src_row = oo;
				src_col = width_q - DIM_W'(1) - ii;
			end
			MODE_CW: begin
				src_row = height_q - DIM_W'(1) - ii;
				src_col = oo;
			end
			MODE_CCW: begin
				src_row = ii;
				src_col = width_q - DIM_W'(1) - oo;
			end
			default: begin
				src_row = oo;
				src_col = ii;
			end
		endcase

		inner_end = (ii == ilen - DIM_W'(1));
		outer_end = (oo == olen - DIM_W'(1));
		if (inner_end) begin
			inner_nxt = '0;
			outer_nxt = outer_end ? '0 : oo + DIM_W'(1);
		end else begin
			inner_nxt = ii + DIM_W'(1);
			outer_nxt = oo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q      <= '0;
			out_outer_q <= '0;
			out_inner_q <= '0;
		end else begin
			if (wr_acc) begin
				load_q <= load_nxt;
			end
			if (rd_acc) begin
				out_outer_q <= outer_nxt;
				out_inner_q <= inner_nxt;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: hold source coordinates (reads) or the write index (writes)
	// ------------------------------------------------------------------
	logic             v_s1;
	logic             rd_s1;
	logic [DIM_W-1:0] row_s1;
	logic [DIM_W-1:0] col_s1;
	logic [TOT_W-1:0] wr_idx_s1;
	logic [PIX_W-1:0] pix_s1;
	logic             inv_s1;
	logic             last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			rd_s1 <= 1'b0;
		end else begin
			v_s1  <= item_acc;
			rd_s1 <= rd_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			row_s1    <= src_row;
			col_s1    <= src_col;
			wr_idx_s1 <= load_cur;
			pix_s1    <= pixel_in;
			inv_s1    <= (mode_q == MODE_INVERT);
			last_s1   <= inner_end && outer_end;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: form the store address (row * width + column)
	// ------------------------------------------------------------------
	logic [TOT_W-1:0]  rd_prod;
	logic [TOT_W-1:0]  rd_idx;
	logic [LIN_W-1:0]  lin_idx;
	logic              v_s2;
	logic              rd_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [PIX_W-1:0]  pix_s2;
	logic              inv_s2;
	logic              last_s2;

	always_comb begin
		rd_prod = TOT_W'(row_s1) * TOT_W'(width_q);
		rd_idx  = rd_prod + TOT_W'(col_s1);
		lin_idx = rd_s1 ? LIN_W'(rd_idx) : LIN_W'(wr_idx_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			rd_s2 <= 1'b0;
		end else begin
			v_s2  <= v_s1;
			rd_s2 <= v_s1 && rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			addr_s2 <= lin_idx[ADDR_W-1:0];
			pix_s2  <= pix_s1;
			inv_s2  <= inv_s1;
			last_s2 <= last_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: store access. Accesses reach the RAM in acceptance order, one
	// per cycle at most, so a read always sees every earlier write.
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] rdata;
	logic             rd_s3;
	logic             inv_s3;
	logic             last_s3;

	ifri_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.en    (v_s2),
		.we    (!rd_s2),
		.addr  (addr_s2),
		.wdata (pix_s2),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s3 <= 1'b0;
		end else begin
			rd_s3 <= v_s2 && rd_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rd_s2) begin
			inv_s3  <= inv_s2;
			last_s3 <= last_s2;
		end
	end

	// ------------------------------------------------------------------
	// Result queue: push every read result, pop on an unstalled word
	// ------------------------------------------------------------------
	out_word_t              push_word;
	out_word_t              head_word;
	logic                   head_valid;
	logic                   pop;
	logic [OFIFO_CNT_W-1:0] fifo_count;

	always_comb begin
		push_word.pixel = inv_s3 ? (PIX_MAX - rdata) : rdata;
		push_word.last  = last_s3;
	end

	assign pop = head_valid && !result_stall;

	ifri_ofifo u_ofifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (rd_s3),
		.push_word  (push_word),
		.pop        (pop),
		.head_valid (head_valid),
		.head_word  (head_word),
		.count      (fifo_count)
	);

	assign result_valid = head_valid;
	assign pixel_out    = head_word.pixel;
	assign frame_last   = head_word.last;

	// ------------------------------------------------------------------
	// Flow control: reads in flight plus queued words never exceed the
	// queue depth, so the pipeline itself never has to stall.
	// ------------------------------------------------------------------
	logic [CRED_W-1:0] inflight;
	logic [CRED_W-1:0] credit_used;

	always_comb begin
		inflight    = CRED_W'(v_s1 && rd_s1) + CRED_W'(rd_s2) + CRED_W'(rd_s3);
		credit_used = CRED_W'(fifo_count) + inflight;
		item_stall  = cfg_pend_q || (credit_used >= CRED_W'(OFIFO_DEPTH));
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_s3 && !pop) |-> (fifo_count < OFIFO_CNT_W'(OFIFO_DEPTH)))
		else $error("result queue pushed while full");

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_used <= CRED_W'(OFIFO_DEPTH))
		else $error("read results exceed queue space");

	a_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> item_stall)
		else $error("item taken before frame size settled");

	a_read_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		rd_acc |=> (v_s1 && rd_s1) ##1 rd_s2 ##1 rd_s3)
		else $error("accepted read lost in pipeline");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !rd_s2) |=> !rd_s3)
		else $error("store write produced a result");
`endif

endmodule
`default_nettype wire

FILE: tb/image_flip_rotate_invert_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// image_flip_rotate_invert_tb: self-checking bench for the flip/rotate engine
// Loads grayscale frames, plays them back under random mode codes and many
// frame sizes, and compares each returned word with a tracked copy of the
// frame store, transformed in order; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module image_flip_rotate_invert_tb;
	import ifri_pkg::*;

	localparam bit OP_WRITE = 1'b0;
	localparam bit OP_READ  = 1'b1;

	// index 3 is not a register; writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam int STORE_DEPTH  = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int ITEM_BUDGET  = 950;

	// Tracks the frame store, the load position and the playback counters,
	// and holds the words the engine still owes us, oldest first.
	class pixel_tracker;
		logic [PIX_W-1:0]  frame_mem [STORE_DEPTH];
		bit                loaded    [STORE_DEPTH];
		int unsigned       load_pos;
		int unsigned       out_row;
		int unsigned       out_col;
		logic [MODE_W-1:0] mode_r;
		logic [DIM_W-1:0]  width_r;
		logic [DIM_W-1:0]  height_r;
		out_word_t         pending_pixels [$];
		int                mismatches;

		function new();
			load_pos   = 0;
			out_row    = 0;
			out_col    = 0;
			mode_r     = MODE_INVERT;
			width_r    = DIM_W'(DIM_RESET);
			height_r   = DIM_W'(DIM_RESET);
			mismatches = 0;
		endfunction

		function int unsigned dim_of(logic [DIM_W-1:0] v, int unsigned maxv);
			if (v == '0) begin
				return 1;
			end
			if (int'(v) > maxv) begin
				return maxv;
			end
			return int'(v);
		endfunction

		function int unsigned cols();
			return dim_of(width_r, MAX_WIDTH_DEF);
		endfunction

		function int unsigned rows();
			return dim_of(height_r, MAX_HEIGHT_DEF);
		endfunction

		function bit turned();
			return (mode_r == MODE_CW) || (mode_r == MODE_CCW);
		endfunction

		function int unsigned outer_len();
			return turned() ? cols() : rows();
		endfunction

		function int unsigned inner_len();
			return turned() ? rows() : cols();
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_MODE:   mode_r   = data[MODE_W-1:0];
			REG_WIDTH:  width_r  = data;
			REG_HEIGHT: height_r = data;
			default: ;
			endcase
		endfunction

		// playback position after the out-of-frame restart, and the address read there
		function void locate(output int unsigned o, output int unsigned i,
				output int unsigned addr);
			int unsigned w;
			int unsigned h;
			int unsigned r;
			int unsigned c;
			w = cols();
			h = rows();
			o = out_row;
			i = out_col;
			if (o >= outer_len() || i >= inner_len()) begin
				o = 0;
				i = 0;
			end
			case (mode_r)
			MODE_VFLIP: begin
				r = h - 1 - o;
				c = i;
			end
			MODE_HFLIP: begin
				r = o;
				c = w - 1 - i;
			end
			MODE_CW: begin
				r = h - 1 - i;
				c = o;
			end
			MODE_CCW: begin
				r = i;
				c = w - 1 - o;
			end
			default: begin
				r = o;
				c = i;
			end
			endcase
			addr = (r * w + c) % STORE_DEPTH;
		endfunction

		// true when the next read lands on a store entry that holds real data
		function bit read_safe();
			int unsigned o;
			int unsigned i;
			int unsigned a;
			locate(o, i, a);
			return loaded[a];
		endfunction

		function void note_item(bit op_v, logic [PIX_W-1:0] pix);
			int unsigned total;
			int unsigned o;
			int unsigned i;
			int unsigned a;
			out_word_t   word;
			total = cols() * rows();
			if (op_v == OP_WRITE) begin
				if (load_pos >= total) begin
					load_pos = 0;
				end
				frame_mem[load_pos % STORE_DEPTH] = pix;
				loaded[load_pos % STORE_DEPTH]    = 1'b1;
				load_pos++;
				if (load_pos >= total) begin
					load_pos = 0;
				end
				return;
			end
			locate(o, i, a);
			word.pixel = (mode_r == MODE_INVERT) ? PIX_MAX - frame_mem[a] : frame_mem[a];
			word.last  = 1'b0;
			i++;
			if (i >= inner_len()) begin
				i = 0;
				o++;
				if (o >= outer_len()) begin
					o = 0;
					word.last = 1'b1;
				end
			end
			out_row = o;
			out_col = i;
			pending_pixels.push_back(word);
		endfunction

		function void check_pixel(logic [PIX_W-1:0] pix, logic last);
			out_word_t want;
			if (pending_pixels.size() == 0) begin
				$error("word with nothing pending: pixel_out %0d frame_last %0d", pix, last);
				mismatches++;
				return;
			end
			want = pending_pixels.pop_front();
			if (pix !== want.pixel) begin
				$error("pixel_out: expected %0d, actual %0d", want.pixel, pix);
				mismatches++;
			end
			if (last !== want.last) begin
				$error("frame_last: expected %0d, actual %0d", want.last, last);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_stall;
	logic                  op           = OP_WRITE;
	logic [PIX_W-1:0]      pixel_in     = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [PIX_W-1:0]      pixel_out;
	logic                  frame_last;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = REG_MODE;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	pixel_tracker tracker = new();

	// steady: no idling on either side for the current frame
	bit          steady      = 1'b0;
	int unsigned sent        = 0;
	int unsigned cycle_count = 0;

	image_flip_rotate_invert dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.op           (op),
		.pixel_in     (pixel_in),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.pixel_out    (pixel_out),
		.frame_last   (frame_last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop: a hung handshake or a missing word ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic int unsigned draw_gap();
		return steady ? 0 : $urandom_range(0, 7);
	endfunction

	// Present one word after a random gap and hold it until the engine takes it.
	// Valid stays high on return so back-to-back words need no extra edge.
	task automatic send_item(bit op_v, logic [PIX_W-1:0] pix);
		int unsigned gap;
		gap = draw_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		op         <= op_v;
		pixel_in   <= pix;
		// stall is sampled before the edge updates it, so this is the taking edge
		do @(posedge clk); while (item_stall);
		tracker.note_item(op_v, pix);
		sent++;
	endtask

	// Leaves cfg_valid high; the caller drops it after the last write of a batch.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(idx, data);
	endtask

	task automatic configure(logic [MODE_W-1:0] m, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
		// pad the mode with random upper bits; only the low three count
		write_reg(REG_MODE, {6'($urandom_range(0, 63)), m});
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, wait out every owed word, then let trailing writes retire.
	task automatic drain();
		item_valid <= 1'b0;
		while (tracker.pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Tidy: load the whole frame, then play it back (sometimes past the wrap).
	// Otherwise: a random mix of loads and reads that may stop mid-frame,
	// which exercises the restart of both counters on the next size change.
	// A read that would hit a never-written entry becomes a load instead.
	task automatic run_frame(bit tidy);
		int unsigned total;
		int unsigned n;
		int unsigned k;
		total = tracker.cols() * tracker.rows();
		if (tidy) begin
			for (k = 0; k < total; k++) begin
				send_item(OP_WRITE, PIX_W'($urandom));
			end
			n = total;
			if ($urandom_range(0, 3) == 0) begin
				n += $urandom_range(1, total);
			end
		end else begin
			n = $urandom_range(1, (2 * total < 80) ? 2 * total : 80);
		end
		for (k = 0; k < n; k++) begin
			if ((tidy || $urandom_range(0, 1) == 1) && tracker.read_safe()) begin
				send_item(OP_READ, PIX_W'($urandom));
			end else begin
				send_item(OP_WRITE, PIX_W'($urandom));
			end
		end
		drain();
	endtask

	// Result side: stall a random number of cycles per word, then take it.
	initial begin
		int unsigned gap;
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			tracker.check_pixel(pixel_out, frame_last);
		end
	end

	initial begin
		int unsigned       frame_no;
		logic [MODE_W-1:0] m;
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: invert, 256 x 256. Load the pixel extremes and read
		// them straight back without touching any register.
		send_item(OP_WRITE, 8'h00);
		send_item(OP_WRITE, 8'hFF);
		send_item(OP_WRITE, 8'hA5);
		send_item(OP_WRITE, 8'h5A);
		send_item(OP_READ, 8'hFF);
		send_item(OP_READ, 8'h00);
		send_item(OP_READ, 8'h5A);
		send_item(OP_READ, 8'hA5);
		drain();

		// Clockwise with junk in the upper mode bits, a write to the spare index,
		// and a 3 x 2 frame: the read counters sit past the new frame and restart,
		// the load position carries on and wraps.
		write_reg(REG_MODE, 9'h1FB);
		write_reg(REG_SPARE, 9'h1FF);
		write_reg(REG_WIDTH, 9'd3);
		write_reg(REG_HEIGHT, 9'd2);
		cfg_valid <= 1'b0;
		repeat (6) send_item(OP_WRITE, PIX_W'($urandom));
		repeat (6) send_item(OP_READ, PIX_W'($urandom));
		drain();

		sent     = 0;
		frame_no = 0;
		while (sent < ITEM_BUDGET) begin
			steady = ($urandom_range(0, 3) == 0);
			m      = MODE_W'($urandom_range(0, 7));
			case (frame_no)
			0: begin
				// full-width single row; also fills the low 256 store entries
				configure(m, 9'd256, 9'd1);
				run_frame(1'b1);
			end
			1: begin
				// height saturates from 511 to 256
				configure(m, 9'd1, 9'h1FF);
				run_frame(1'b0);
			end
			2: begin
				// width saturates from 400 to 256
				configure(m, 9'd400, 9'd1);
				run_frame(1'b0);
			end
			3: begin
				// zero width acts as one
				configure(m, 9'd0, 9'd3);
				run_frame(1'b1);
			end
			4: begin
				// zero height acts as one
				configure(m, 9'd3, 9'd0);
				run_frame(1'b1);
			end
			default: begin
				w = DIM_W'($urandom_range(1, ($urandom_range(0, 4) == 0) ? 16 : 6));
				h = DIM_W'($urandom_range(1, ($urandom_range(0, 4) == 0) ? 16 : 6));
				configure(m, w, h);
				run_frame($urandom_range(0, 9) < 7);
			end
			endcase
			frame_no++;
		end

		steady = 1'b0;
		drain();
		if (tracker.mismatches == 0 && tracker.pending_pixels.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/ifri_pkg.sv
hw/rtl/ifri_store.sv
hw/rtl/ifri_ofifo.sv
hw/rtl/image_flip_rotate_invert.sv
tb/image_flip_rotate_invert_tb.sv
